FILE: sv/hcbd_pkg.sv
// shared types, constants and the keyboard scan table of the bus decoder
// no dependencies
package hcbd_pkg;

    localparam int ROM_BYTES   = 4096;
    localparam int RAM_BYTES   = 6144;
    localparam int KEY_COUNT_D = 53;

    localparam int ROM_AW = $clog2(ROM_BYTES);
    localparam int RAM_AW = $clog2(RAM_BYTES);
    localparam int KEY_W  = 6;

    localparam logic [15:0] ROMB_BASE  = 16'h1000;
    localparam logic [15:0] IO_BASE    = 16'h2000;
    localparam logic [15:0] RAM_BASE   = 16'h2800;
    localparam logic [15:0] OPEN_BASE  = 16'h4000;
    localparam logic [15:0] RAM_FORCE  = 16'h0080;
    localparam logic [5:0]  LATCH_OFS  = 6'h38;
    localparam logic [5:0]  SCAN_LAST  = 6'd53;
    localparam logic [7:0]  LATCH_MASK = 8'b1111_1100;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_KEY   = 2'd2,
        OP_LOAD  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        SRC_ROMA = 2'd0,
        SRC_ROMB = 2'd1,
        SRC_RAM  = 2'd2,
        SRC_BYTE = 2'd3
    } t_src;

    typedef struct packed {
        t_src       src;
        logic [7:0] byte_val;
    } t_rd_info;

    function automatic logic [KEY_W-1:0] scan_key(input logic [KEY_W-1:0] pos);
        logic [KEY_W-1:0] k;
        k = pos;
        case (pos)
            6'd42:   k = 6'd51;
            6'd43:   k = 6'd42;
            6'd44:   k = 6'd43;
            6'd45:   k = 6'd44;
            6'd46:   k = 6'd45;
            6'd47:   k = 6'd46;
            6'd48:   k = 6'd52;
            6'd50:   k = 6'd47;
            6'd51:   k = 6'd50;
            6'd52:   k = 6'd48;
            default: k = pos;
        endcase
        return k;
    endfunction

endpackage

FILE: sv/hcbd_if.sv
// valid/ready channels of the bus decoder: input words and read results
// depends on hcbd_pkg
interface hcbd_in_if;
    import hcbd_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        op;
    logic [15:0]       address;
    logic [7:0]        data_in;
    logic [7:0]        floating_bus;
    logic [KEY_W-1:0]  key_number;
    logic              key_down;
    logic              rom_choice;

    modport source (
        output valid, op, address, data_in, floating_bus, key_number, key_down, rom_choice,
        input  ready
    );
    modport sink (
        input  valid, op, address, data_in, floating_bus, key_number, key_down, rom_choice,
        output ready
    );
endinterface

interface hcbd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       read_done;

    modport source (output valid, read_data, read_done, input ready);
    modport sink (input valid, read_data, read_done, output ready);
endinterface

FILE: sv/hcbd_mem.sv
// single write port, single registered read port byte memory
// depends on hcbd_pkg
module hcbd_mem #(
    parameter int DEPTH = hcbd_pkg::ROM_BYTES
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [7:0]               i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [7:0]               o_rdata
);
    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: sv/hcbd_io.sv
// keyboard matrix state, control latch and the i/o window read byte
// depends on hcbd_pkg
module hcbd_io #(
    parameter int KEY_COUNT = hcbd_pkg::KEY_COUNT_D
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_key_we,
    input  logic [hcbd_pkg::KEY_W-1:0] i_key_number,
    input  logic                      i_key_down,
    input  logic                      i_latch_we,
    input  logic [7:0]                i_latch_data,
    input  logic [5:0]                i_offset,
    output logic [7:0]                o_io_byte,
    output logic                      o_latch_b7
);
    import hcbd_pkg::*;

    localparam int KIDX_W = $clog2(KEY_COUNT);
    localparam logic [KEY_W:0] KEY_LIMIT = (KEY_W+1)'(KEY_COUNT);

    logic [KEY_COUNT-1:0] r_keys;
    logic [7:0]           r_latch;
    logic [KEY_W-1:0]     scan_pos;
    logic [KEY_W-1:0]     key_sel;
    logic                 level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keys  <= '0;
            r_latch <= '0;
        end else begin
            if (i_key_we && ({1'b0, i_key_number} < KEY_LIMIT)) begin
                r_keys[i_key_number[KIDX_W-1:0]] <= i_key_down;
            end
            if (i_latch_we) begin
                r_latch <= i_latch_data & LATCH_MASK;
            end
        end
    end

    always_comb begin
        scan_pos = i_offset - 6'd1;
        key_sel  = scan_key(scan_pos);
        level    = 1'b1;
        if (i_offset != '0 && i_offset <= SCAN_LAST && ({1'b0, key_sel} < KEY_LIMIT)) begin
            level = ~r_keys[key_sel[KIDX_W-1:0]];
        end
        if (i_offset < LATCH_OFS) begin
            o_io_byte = {7'd0, level};
        end else begin
            o_io_byte = r_latch;
        end
    end

    assign o_latch_b7 = r_latch[7];
endmodule

FILE: sv/hcbd_res.sv
// read pipeline: decoded read stage, data select and result register
// depends on hcbd_pkg and hcbd_if
module hcbd_res (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_rd_load,
    input  hcbd_pkg::t_rd_info   i_rd_info,
    input  logic [7:0]           i_roma_data,
    input  logic [7:0]           i_romb_data,
    input  logic [7:0]           i_ram_data,
    output logic                 o_take,
    hcbd_out_if.source           o_out
);
    import hcbd_pkg::*;

    logic       r_s1_valid;
    t_rd_info   r_s1_info;
    logic       r_out_valid;
    logic [7:0] r_out_data;
    logic       s1_adv;
    logic [7:0] sel_data;

    assign s1_adv = !r_out_valid || o_out.ready;
    assign o_take = !r_s1_valid || s1_adv;

    always_comb begin
        unique case (r_s1_info.src)
            SRC_ROMA: sel_data = i_roma_data;
            SRC_ROMB: sel_data = i_romb_data;
            SRC_RAM:  sel_data = i_ram_data;
            default:  sel_data = r_s1_info.byte_val;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_take) begin
                r_s1_valid <= i_rd_load;
            end
            if (s1_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_rd_load) begin
            r_s1_info <= i_rd_info;
        end
        if (s1_adv && r_s1_valid) begin
            r_out_data <= sel_data;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.read_data = r_out_data;
    assign o_out.read_done = 1'b1;
endmodule

FILE: sv/home_computer_bus_decoder_core.sv
// bus decoder: a word is taken every cycle while the read stage can move on
// a read answers through the rom/ram read register and then the result register;
// writes, key changes and rom loads finish at acceptance
// synchronous active-low reset clears the latch, the key map, the rom select and
// the pipeline valid flags; rom and ram contents are not cleared
module home_computer_bus_decoder_core #(
    parameter int KEY_COUNT = hcbd_pkg::KEY_COUNT_D
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    hcbd_in_if.sink    i_in,
    hcbd_out_if.source o_out
);
    import hcbd_pkg::*;

    logic             r_romb_fitted;
    logic             take;
    logic             accept;
    t_op              op;
    logic [15:0]      addr;
    logic             is_read;
    logic             in_io;
    logic             in_ram;
    logic             latch_b7;
    logic [7:0]       io_byte;
    logic [15:0]      ram_a;
    logic [15:0]      ram_diff;
    t_rd_info         rd_info;
    logic [7:0]       roma_data;
    logic [7:0]       romb_data;
    logic [7:0]       ram_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_romb_fitted <= 1'b0;
        end else if (i_cfg_we) begin
            r_romb_fitted <= i_cfg_wdata;
        end
    end

    assign i_in.ready = take && i_rst_n;
    assign accept     = i_in.valid && take && i_rst_n;
    assign op         = t_op'(i_in.op);
    assign addr       = i_in.address;
    assign is_read    = (op == OP_READ);
    assign in_io      = (addr >= IO_BASE) && (addr < RAM_BASE);
    assign in_ram     = (addr >= RAM_BASE) && (addr < OPEN_BASE);
    assign ram_a      = latch_b7 ? addr : (addr | RAM_FORCE);
    assign ram_diff   = ram_a - RAM_BASE;

    always_comb begin
        rd_info.byte_val = i_in.floating_bus;
        if (addr < ROMB_BASE) begin
            rd_info.src = SRC_ROMA;
        end else if (addr < IO_BASE && r_romb_fitted) begin
            rd_info.src = SRC_ROMB;
        end else if (addr < RAM_BASE) begin
            rd_info.src      = SRC_BYTE;
            rd_info.byte_val = io_byte;
        end else if (addr < OPEN_BASE) begin
            rd_info.src = SRC_RAM;
        end else begin
            rd_info.src = SRC_BYTE;
        end
    end

    hcbd_io #(.KEY_COUNT(KEY_COUNT)) u_io (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_key_we     (accept && op == OP_KEY),
        .i_key_number (i_in.key_number),
        .i_key_down   (i_in.key_down),
        .i_latch_we   (accept && op == OP_WRITE && in_io && addr[5:0] >= LATCH_OFS),
        .i_latch_data (i_in.data_in),
        .i_offset     (addr[5:0]),
        .o_io_byte    (io_byte),
        .o_latch_b7   (latch_b7)
    );

    hcbd_mem #(.DEPTH(ROM_BYTES)) u_roma (
        .i_clk   (i_clk),
        .i_we    (accept && op == OP_LOAD && !i_in.rom_choice),
        .i_waddr (addr[ROM_AW-1:0]),
        .i_wdata (i_in.data_in),
        .i_re    (accept),
        .i_raddr (addr[ROM_AW-1:0]),
        .o_rdata (roma_data)
    );

    hcbd_mem #(.DEPTH(ROM_BYTES)) u_romb (
        .i_clk   (i_clk),
        .i_we    (accept && op == OP_LOAD && i_in.rom_choice),
        .i_waddr (addr[ROM_AW-1:0]),
        .i_wdata (i_in.data_in),
        .i_re    (accept),
        .i_raddr (addr[ROM_AW-1:0]),
        .o_rdata (romb_data)
    );

    hcbd_mem #(.DEPTH(RAM_BYTES)) u_ram (
        .i_clk   (i_clk),
        .i_we    (accept && op == OP_WRITE && in_ram),
        .i_waddr (ram_diff[RAM_AW-1:0]),
        .i_wdata (i_in.data_in),
        .i_re    (accept),
        .i_raddr (ram_diff[RAM_AW-1:0]),
        .o_rdata (ram_data)
    );

    hcbd_res u_res (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_load   (i_in.valid && is_read),
        .i_rd_info   (rd_info),
        .i_roma_data (roma_data),
        .i_romb_data (romb_data),
        .i_ram_data  (ram_data),
        .o_take      (take),
        .o_out       (o_out)
    );
endmodule
